/* sv/vocp_pkg.sv */
package vocp_pkg;

	// field widths
	localparam int unsigned CODE_W = 12;
	localparam int unsigned TEMP_W = 12;
	localparam int unsigned PPM_W  = 10;
	localparam int unsigned BASE_W = 12;

	// baseline divider: constant numerator over 33 * (11200 + rs)
	localparam logic [30:0] BASE_NUM = 31'd1146600000;
	localparam int unsigned D1_BITS = 12;
	localparam int unsigned D1_STEP = 4;
	localparam int unsigned D1_ST   = D1_BITS / D1_STEP;

	// ratio divider: quotient overflow is signalled by a flag
	localparam int unsigned D2_BITS = 16;
	localparam int unsigned D2_STEP = 4;
	localparam int unsigned D2_ST   = D2_BITS / D2_STEP;

	// code limits
	localparam logic [CODE_W-1:0] CODE_LOW  = 12'd100;
	localparam logic [CODE_W-1:0] CODE_POLE = 12'd3102;
	localparam logic [7:0]        PPM_FLOOR = 8'd100;

	localparam logic [PPM_W-1:0] MAX_PPM_RST = 10'd100;

	// side data through the baseline divider
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [25:0]       mag;
		logic              low;
		logic              pole;
	} side_t;

	// side data through the ratio divider
	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic              low;
		logic              pole;
		logic              ovf;
	} tail_t;

endpackage

/* sv/voc_ppm_from_adc_with_temp_baseline_unit.sv */
// Gas-sensor concentration estimator, one result per input transfer.
// s_tvalid/s_tready/s_tdata carry adc_code and temp_tenths; m_* carries
// voc_ppm and baseline_code. cfg_valid/cfg_ready/cfg_data write max_ppm,
// the upper clamp (always ready; write it only while the pipe is empty).
// Throughput: one item per cycle while results are taken, no state between items.
// Stages from input transfer to m_tvalid:
//   1 stage baseline line segment, 3 stages of the baseline divider
//   (4 quotient bits each), 1 multiply stage, 4 stages of the ratio
//   divider (4 quotient bits each), 1 curve stage, 1 output register.
// The whole pipe advances when the output register is empty or taken;
// when the receiver stalls with a result waiting, every stage holds and
// s_tready drops, so nothing is lost or repeated. Bubbles stay in place.
// Reset (arst_n low) clears all valid bits and sets max_ppm to 100.
module voc_ppm_from_adc_with_temp_baseline_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [11:0] adc_code, [23:12] temp_tenths
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [9:0] voc_ppm, [21:10] baseline_code, [23:22] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data   // max_ppm
);

	localparam int unsigned D1_ST = vocp_pkg::D1_ST;
	localparam int unsigned D2_ST = vocp_pkg::D2_ST;

	logic en;
	logic [vocp_pkg::PPM_W-1:0] max_ppm_q;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ppm_q <= vocp_pkg::MAX_PPM_RST;
		end else if (cfg_valid) begin
			max_ppm_q <= cfg_data;
		end
	end

	// global advance
	logic v_s11;
	assign en       = !v_s11 || m_tready;
	assign s_tready = en;

	// ---------------- stage 1: segment line and divisor ----------------
	logic [11:0]        in_code;
	logic signed [21:0] t_x;
	logic signed [21:0] lin;
	logic [20:0]        rs_sum;
	logic [24:0]        den1_n;
	vocp_pkg::side_t    side_n;

	assign in_code = s_tdata[11:0];
	assign t_x     = {{10{s_tdata[23]}}, s_tdata[23:12]};

	always_comb begin
		priority if (t_x <= 22'sd200) begin
			lin = 22'sd17000 - 22'sd35 * t_x;
		end else if (t_x <= 22'sd300) begin
			lin = 22'sd15000 - 22'sd25 * t_x;
		end else if (t_x <= 22'sd400) begin
			lin = 22'sd13800 - 22'sd21 * t_x;
		end else if (t_x <= 22'sd600) begin
			lin = 22'sd13000 - 22'sd19 * t_x;
		end else begin
			lin = 22'sd1600;
		end
	end

	// 11200 + 8 * lin, then times 33
	assign rs_sum = 21'd11200 + {lin[17:0], 3'b000};
	assign den1_n = {rs_sum[19:0], 5'b00000} + 25'(rs_sum);

	always_comb begin
		side_n.code = in_code;
		side_n.mag  = 26'd62040000 - 26'(in_code) * 26'd20000;
		side_n.low  = (in_code <= vocp_pkg::CODE_LOW);
		side_n.pole = (in_code >= vocp_pkg::CODE_POLE);
	end

	logic            v_s1;
	logic [24:0]     den1_s1;
	vocp_pkg::side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den1_s1 <= den1_n;
			side_s1 <= side_n;
		end
	end

	// ---------------- stages 2..4: baseline divider ----------------
	logic [25:0]                   d1_rem_s  [D1_ST-1];
	logic [24:0]                   d1_den_s  [D1_ST-1];
	logic [vocp_pkg::D1_BITS-1:0]  d1_q_s    [D1_ST];
	logic                          d1_v_s    [D1_ST];
	vocp_pkg::side_t               d1_side_s [D1_ST];

	for (genvar k = 0; k < D1_ST; k++) begin : g_d1
		logic [25:0]                  rem_in;
		logic [24:0]                  den_in;
		logic [vocp_pkg::D1_BITS-1:0] q_in;
		logic                         v_in;
		vocp_pkg::side_t              side_in;
		logic [25:0]                  rem_n;
		logic [vocp_pkg::D1_BITS-1:0] q_n;

		if (k == 0) begin : g_first
			assign rem_in  = 26'(vocp_pkg::BASE_NUM[30:vocp_pkg::D1_BITS]);
			assign den_in  = den1_s1;
			assign q_in    = '0;
			assign v_in    = v_s1;
			assign side_in = side_s1;
		end else begin : g_next
			assign rem_in  = d1_rem_s[k-1];
			assign den_in  = d1_den_s[k-1];
			assign q_in    = d1_q_s[k-1];
			assign v_in    = d1_v_s[k-1];
			assign side_in = d1_side_s[k-1];
		end

		// restoring steps, one quotient bit each
		always_comb begin
			rem_n = rem_in;
			q_n   = q_in;
			for (int j = 0; j < vocp_pkg::D1_STEP; j++) begin
				rem_n = {rem_n[24:0],
					vocp_pkg::BASE_NUM[vocp_pkg::D1_BITS-1-k*vocp_pkg::D1_STEP-j]};
				if (rem_n >= {1'b0, den_in}) begin
					rem_n = rem_n - {1'b0, den_in};
					q_n   = {q_n[vocp_pkg::D1_BITS-2:0], 1'b1};
				end else begin
					q_n   = {q_n[vocp_pkg::D1_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_v_s[k] <= 1'b0;
			end else if (en) begin
				d1_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d1_q_s[k]    <= q_n;
				d1_side_s[k] <= side_in;
			end
		end

		if (k < D1_ST - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					d1_rem_s[k] <= rem_n;
					d1_den_s[k] <= den_in;
				end
			end
		end
	end

	// ---------------- stage 5: numerator and divisor of the ratio ----------------
	logic [vocp_pkg::BASE_W-1:0] base_c;
	logic [12:0]                 kfac;
	logic                        v_s5;
	logic [37:0]                 num_s5;
	logic [24:0]                 den2_s5;
	vocp_pkg::tail_t             tail_s5;

	assign base_c = d1_q_s[D1_ST-1];
	assign kfac   = 13'd6204 - {base_c, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= d1_v_s[D1_ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5       <= 38'(d1_side_s[D1_ST-1].mag) * 38'(base_c);
			den2_s5      <= 25'(d1_side_s[D1_ST-1].code) * 25'(kfac);
			tail_s5.base <= base_c;
			tail_s5.low  <= d1_side_s[D1_ST-1].low;
			tail_s5.pole <= d1_side_s[D1_ST-1].pole;
			tail_s5.ovf  <= 1'b0;
		end
	end

	// ---------------- stages 6..9: ratio divider ----------------
	logic [25:0]                   d2_rem_s  [D2_ST-1];
	logic [24:0]                   d2_den_s  [D2_ST-1];
	logic [vocp_pkg::D2_BITS-1:0]  d2_lo_s   [D2_ST-1];
	logic [vocp_pkg::D2_BITS-1:0]  d2_q_s    [D2_ST];
	logic                          d2_v_s    [D2_ST];
	vocp_pkg::tail_t               d2_tail_s [D2_ST];

	for (genvar k = 0; k < D2_ST; k++) begin : g_d2
		logic [25:0]                  rem_in;
		logic [24:0]                  den_in;
		logic [vocp_pkg::D2_BITS-1:0] lo_in;
		logic [vocp_pkg::D2_BITS-1:0] q_in;
		logic                         v_in;
		vocp_pkg::tail_t              tail_in;
		logic [25:0]                  rem_n;
		logic [vocp_pkg::D2_BITS-1:0] q_n;

		if (k == 0) begin : g_first
			assign rem_in = 26'(num_s5[37:vocp_pkg::D2_BITS]);
			assign den_in = den2_s5;
			assign lo_in  = num_s5[vocp_pkg::D2_BITS-1:0];
			assign q_in   = '0;
			assign v_in   = v_s5;
			// quotient would not fit: ratio far above the curve range
			always_comb begin
				tail_in     = tail_s5;
				tail_in.ovf = (rem_in >= {1'b0, den_in});
			end
		end else begin : g_next
			assign rem_in  = d2_rem_s[k-1];
			assign den_in  = d2_den_s[k-1];
			assign lo_in   = d2_lo_s[k-1];
			assign q_in    = d2_q_s[k-1];
			assign v_in    = d2_v_s[k-1];
			assign tail_in = d2_tail_s[k-1];
		end

		always_comb begin
			rem_n = rem_in;
			q_n   = q_in;
			for (int j = 0; j < vocp_pkg::D2_STEP; j++) begin
				rem_n = {rem_n[24:0], lo_in[vocp_pkg::D2_BITS-1-k*vocp_pkg::D2_STEP-j]};
				if (rem_n >= {1'b0, den_in}) begin
					rem_n = rem_n - {1'b0, den_in};
					q_n   = {q_n[vocp_pkg::D2_BITS-2:0], 1'b1};
				end else begin
					q_n   = {q_n[vocp_pkg::D2_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_v_s[k] <= 1'b0;
			end else if (en) begin
				d2_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d2_q_s[k]    <= q_n;
				d2_tail_s[k] <= tail_in;
			end
		end

		if (k < D2_ST - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					d2_rem_s[k] <= rem_n;
					d2_den_s[k] <= den_in;
					d2_lo_s[k]  <= lo_in;
				end
			end
		end
	end

	// ---------------- stage 10: piecewise-linear curve ----------------
	logic [vocp_pkg::D2_BITS-1:0] x;
	vocp_pkg::tail_t              tl;
	logic [12:0]                  slope;
	logic signed [30:0]           icpt;
	logic signed [30:0]           acc;
	logic [1:0]                   sel;
	logic [7:0]                   y_n;

	localparam logic [1:0] SEL_ZERO  = 2'd0;
	localparam logic [1:0] SEL_LINE  = 2'd1;
	localparam logic [1:0] SEL_FLOOR = 2'd2;

	assign x  = d2_q_s[D2_ST-1];
	assign tl = d2_tail_s[D2_ST-1];

	always_comb begin
		slope = 13'd0;
		icpt  = 31'sd0;
		priority if (tl.ovf || x > 16'd5000) begin
			sel = SEL_ZERO;
		end else if (x >= 16'd2000) begin
			sel = SEL_LINE;  slope = 13'd196;  icpt = 31'sd1048576;
		end else if (x >= 16'd900) begin
			sel = SEL_LINE;  slope = 13'd1191; icpt = 31'sd3038488;
		end else if (x >= 16'd300) begin
			sel = SEL_LINE;  slope = 13'd7645; icpt = 31'sd8847360;
		end else begin
			sel = SEL_FLOOR;
		end
	end

	assign acc = icpt - $signed(31'(slope) * 31'(x));

	// low code forces zero; past the pole the ratio is negative
	always_comb begin
		priority if (tl.low) begin
			y_n = 8'd0;
		end else if (tl.pole) begin
			y_n = vocp_pkg::PPM_FLOOR;
		end else if (sel == SEL_FLOOR) begin
			y_n = vocp_pkg::PPM_FLOOR;
		end else if (sel == SEL_LINE && !acc[30]) begin
			y_n = acc[23:16];
		end else begin
			y_n = 8'd0;
		end
	end

	logic                        v_s10;
	logic [7:0]                  y_s10;
	logic [vocp_pkg::BASE_W-1:0] base_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= d2_v_s[D2_ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s10    <= y_n;
			base_s10 <= tl.base;
		end
	end

	// ---------------- stage 11: clamp and output register ----------------
	logic [vocp_pkg::PPM_W-1:0]  ppm_s11;
	logic [vocp_pkg::BASE_W-1:0] base_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ppm_s11  <= (10'(y_s10) > max_ppm_q) ? max_ppm_q : 10'(y_s10);
			base_s11 <= base_s10;
		end
	end

	assign m_tvalid = v_s11;
	assign m_tdata  = {2'b00, base_s11, ppm_s11};

endmodule

/* sv/vocp_checker.sv */
module vocp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input side only blocked by a waiting result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output stall");

	// baseline lies within the line's reach
	a_base: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[21:10] >= 12'd48 && m_tdata[21:10] <= 12'd1447))
		else $error("baseline out of range");

	// curve never exceeds its floor value
	a_ppm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:0] <= 10'd100 && m_tdata[23:22] == 2'b00))
		else $error("ppm out of range");

endmodule

bind voc_ppm_from_adc_with_temp_baseline_unit vocp_checker u_vocp_checker (.*);
